// ===== hw/rtl/smf_pkg.sv =====
// smf_pkg: shared types and constants for the sensor mean and fault alarm block
// depends on nothing; used by every module under hw/rtl except smf_ram
package smf_pkg;

    localparam int SMF_MAX_SENSORS = 16;
    localparam int SMF_DATA_W      = 16;
    localparam int SMF_MASK_W      = 16;
    localparam int SMF_CNT_CFG_W   = 5;
    localparam int SMF_DEV_W       = 15;
    localparam int SMF_CFG_IDX_W   = 3;

    // register reset values, Q8.8 where signed
    localparam logic [SMF_CNT_CFG_W-1:0] SMF_TEMP_COUNT_RST = 5'd4;
    localparam logic [SMF_CNT_CFG_W-1:0] SMF_HUM_COUNT_RST  = 5'd4;
    localparam logic signed [SMF_DATA_W-1:0] SMF_TEMP_HIGH_RST = 16'sd7680;
    localparam logic signed [SMF_DATA_W-1:0] SMF_TEMP_LOW_RST  = 16'sd2560;
    localparam logic signed [SMF_DATA_W-1:0] SMF_HUM_HIGH_RST  = 16'sd15360;
    localparam logic signed [SMF_DATA_W-1:0] SMF_HUM_LOW_RST   = 16'sd10240;
    localparam logic [SMF_DEV_W-1:0] SMF_TEMP_DEV_RST = 15'd3840;
    localparam logic [SMF_DEV_W-1:0] SMF_HUM_DEV_RST  = 15'd5120;

    typedef enum logic [SMF_CFG_IDX_W-1:0] {
        CFG_TEMP_COUNT = 3'd0,
        CFG_HUM_COUNT  = 3'd1,
        CFG_TEMP_HIGH  = 3'd2,
        CFG_TEMP_LOW   = 3'd3,
        CFG_HUM_HIGH   = 3'd4,
        CFG_HUM_LOW    = 3'd5,
        CFG_TEMP_DEV   = 3'd6,
        CFG_HUM_DEV    = 3'd7
    } t_cfg_reg;

    // sequencer to lane control
    typedef struct packed {
        logic wr;   // store an incoming reading
        logic rd;   // issue a scan read
        logic chk;  // scan is the check pass, otherwise the sum pass
        logic clr;  // clear sum and fault mask
    } t_lane_ctl;

endpackage

// ===== hw/rtl/sensor_mean_fault_alarm.sv =====
// sensor_mean_fault_alarm: top level, sequencer, configuration registers, output register
// depends on smf_pkg, smf_lane, smf_ram and smf_div
//
//  channel  | signals                                   | transfers when
//  ---------+-------------------------------------------+-------------------------------
//  input    | i_in_valid, o_in_ready, item fields       | i_in_valid & o_in_ready
//  output   | o_out_valid, i_out_ready, result fields   | o_out_valid & i_out_ready
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data           | i_cfg_we, no wait
//
// a store transaction leaves the block in idle, so it stays ready for the next item
// an evaluate transaction scans N entries per store, N the larger count, in these steps:
// one sum scan over both stores, two passes of the shared bit-serial divider, one check scan
// the read latency of the stores sets the scan length: one entry is read per cycle, and
// the scan ends once the last read has landed in the sum or the fault mask
// no clearing pass after reset: per-entry valid bits make unwritten entries read as zero
// a finished result waits in the output register; stores are taken meanwhile, and a
// following evaluate stalls only at its last step until the register is free
module sensor_mean_fault_alarm import smf_pkg::*; #(
    parameter int MAX_SENSORS = SMF_MAX_SENSORS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_action,
    input  logic                         i_is_humidity,
    input  logic [3:0]                   i_sensor_index,
    input  logic signed [SMF_DATA_W-1:0] i_reading,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [SMF_DATA_W-1:0] o_mean_temp,
    output logic signed [SMF_DATA_W-1:0] o_mean_hum,
    output logic [SMF_MASK_W-1:0]        o_temp_fault_mask,
    output logic [SMF_MASK_W-1:0]        o_hum_fault_mask,
    output logic                         o_cooling_on,
    output logic                         o_cooling_off,
    output logic                         o_dehumidify_on,
    output logic                         o_humidify_on,
    // configuration port
    input  logic                         i_cfg_we,
    input  logic [SMF_CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [SMF_DATA_W-1:0]        i_cfg_data
);

    localparam int AW    = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CNT_W = $clog2(MAX_SENSORS + 1);
    localparam int SUM_W = SMF_DATA_W + $clog2(MAX_SENSORS);
    localparam int EW    = (CNT_W > SMF_CNT_CFG_W) ? CNT_W : SMF_CNT_CFG_W;
    localparam int IW    = (CNT_W > 4) ? CNT_W : 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV_T,
        S_DIV_H,
        S_CHK,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [SMF_CNT_CFG_W-1:0]     r_temp_count;
    logic [SMF_CNT_CFG_W-1:0]     r_hum_count;
    logic signed [SMF_DATA_W-1:0] r_temp_high;
    logic signed [SMF_DATA_W-1:0] r_temp_low;
    logic signed [SMF_DATA_W-1:0] r_hum_high;
    logic signed [SMF_DATA_W-1:0] r_hum_low;
    logic [SMF_DEV_W-1:0]         r_temp_dev;
    logic [SMF_DEV_W-1:0]         r_hum_dev;

    // scan and evaluation state
    logic [CNT_W-1:0]             r_idx;
    logic                         r_rd_d;
    logic signed [SMF_DATA_W-1:0] r_mean_t;
    logic signed [SMF_DATA_W-1:0] r_mean_h;

    // output register
    logic                         r_o_valid;
    logic signed [SMF_DATA_W-1:0] r_o_mean_t;
    logic signed [SMF_DATA_W-1:0] r_o_mean_h;
    logic [SMF_MASK_W-1:0]        r_o_mask_t;
    logic [SMF_MASK_W-1:0]        r_o_mask_h;
    logic                         r_o_cool_on;
    logic                         r_o_cool_off;
    logic                         r_o_dehum_on;
    logic                         r_o_hum_on;

    logic                         w_in_acc;
    logic [CNT_W-1:0]             w_nt;
    logic [CNT_W-1:0]             w_nh;
    logic [CNT_W-1:0]             w_nmax;
    logic                         w_issue;
    logic                         w_scan_end;
    logic                         w_wr_ok;
    logic [AW-1:0]                w_wr_idx;
    t_lane_ctl                    w_ctl_t;
    t_lane_ctl                    w_ctl_h;
    logic signed [SUM_W-1:0]      w_sum_t;
    logic signed [SUM_W-1:0]      w_sum_h;
    logic [SMF_MASK_W-1:0]        w_mask_t;
    logic [SMF_MASK_W-1:0]        w_mask_h;
    logic                         w_div_start;
    logic signed [SUM_W-1:0]      w_div_num;
    logic [CNT_W-1:0]             w_div_den;
    logic                         w_div_done;
    logic signed [SMF_DATA_W-1:0] w_div_quot;
    logic                         w_out_free;
    logic                         w_res_load;

    // count of zero means one sensor, counts above the store depth are clamped
    function automatic logic [CNT_W-1:0] eff_count(input logic [SMF_CNT_CFG_W-1:0] c);
        logic [EW-1:0] v;
        v = EW'(c);
        if (v == '0) begin
            v = EW'(1);
        end else if (v > EW'(MAX_SENSORS)) begin
            v = EW'(MAX_SENSORS);
        end
        return v[CNT_W-1:0];
    endfunction

    assign w_nt   = eff_count(r_temp_count);
    assign w_nh   = eff_count(r_hum_count);
    assign w_nmax = (w_nt > w_nh) ? w_nt : w_nh;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;

    // stores to an index at or above the count of its kind are dropped
    assign w_wr_ok  = w_in_acc & ~i_action &
                      (IW'(i_sensor_index) < IW'(i_is_humidity ? w_nh : w_nt));
    assign w_wr_idx = AW'(i_sensor_index);

    // both stores are scanned together at the same address
    assign w_issue    = ((r_state == S_SUM) || (r_state == S_CHK)) && (r_idx < w_nmax);
    assign w_scan_end = ~w_issue & ~r_rd_d;

    always_comb begin
        w_ctl_t.wr  = w_wr_ok & ~i_is_humidity;
        w_ctl_t.rd  = w_issue;
        w_ctl_t.chk = (r_state == S_CHK);
        w_ctl_t.clr = w_in_acc & i_action;
        w_ctl_h     = w_ctl_t;
        w_ctl_h.wr  = w_wr_ok & i_is_humidity;
    end

    smf_lane #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_lane_temp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl_t),
        .i_wr_idx    (w_wr_idx),
        .i_wr_data   (i_reading),
        .i_rd_idx    (r_idx[AW-1:0]),
        .i_count     (w_nt),
        .i_mean      (r_mean_t),
        .i_dev_limit (r_temp_dev),
        .o_sum       (w_sum_t),
        .o_mask      (w_mask_t)
    );

    smf_lane #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_lane_hum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl_h),
        .i_wr_idx    (w_wr_idx),
        .i_wr_data   (i_reading),
        .i_rd_idx    (r_idx[AW-1:0]),
        .i_count     (w_nh),
        .i_mean      (r_mean_h),
        .i_dev_limit (r_hum_dev),
        .o_sum       (w_sum_h),
        .o_mask      (w_mask_h)
    );

    // one divider, temperature mean first, humidity mean right after
    assign w_div_start = ((r_state == S_SUM) && w_scan_end) ||
                         ((r_state == S_DIV_T) && w_div_done);
    assign w_div_num   = (r_state == S_SUM) ? w_sum_t : w_sum_h;
    assign w_div_den   = (r_state == S_SUM) ? w_nt : w_nh;

    smf_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign w_out_free = ~r_o_valid | i_out_ready;
    // a new result enters the output register in the same cycle the old one leaves
    assign w_res_load = (r_state == S_OUT) & w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_rd_d       <= 1'b0;
            r_o_valid    <= 1'b0;
            r_temp_count <= SMF_TEMP_COUNT_RST;
            r_hum_count  <= SMF_HUM_COUNT_RST;
            r_temp_high  <= SMF_TEMP_HIGH_RST;
            r_temp_low   <= SMF_TEMP_LOW_RST;
            r_hum_high   <= SMF_HUM_HIGH_RST;
            r_hum_low    <= SMF_HUM_LOW_RST;
            r_temp_dev   <= SMF_TEMP_DEV_RST;
            r_hum_dev    <= SMF_HUM_DEV_RST;
        end else begin
            // configuration writes take effect at once; keep them to idle periods
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_TEMP_COUNT: r_temp_count <= i_cfg_data[SMF_CNT_CFG_W-1:0];
                    CFG_HUM_COUNT:  r_hum_count  <= i_cfg_data[SMF_CNT_CFG_W-1:0];
                    CFG_TEMP_HIGH:  r_temp_high  <= $signed(i_cfg_data);
                    CFG_TEMP_LOW:   r_temp_low   <= $signed(i_cfg_data);
                    CFG_HUM_HIGH:   r_hum_high   <= $signed(i_cfg_data);
                    CFG_HUM_LOW:    r_hum_low    <= $signed(i_cfg_data);
                    CFG_TEMP_DEV:   r_temp_dev   <= i_cfg_data[SMF_DEV_W-1:0];
                    CFG_HUM_DEV:    r_hum_dev    <= i_cfg_data[SMF_DEV_W-1:0];
                    default: ;
                endcase
            end

            // scan address counter and read-data tracking
            r_rd_d <= w_issue;
            if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end

            if (w_res_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_action) begin
                        r_idx   <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    // the scan ends once the last read has been added to the sums
                    if (w_scan_end) begin
                        r_state <= S_DIV_T;
                    end
                end
                S_DIV_T: begin
                    if (w_div_done) begin
                        r_mean_t <= w_div_quot;
                        r_state  <= S_DIV_H;
                    end
                end
                S_DIV_H: begin
                    if (w_div_done) begin
                        r_mean_h <= w_div_quot;
                        r_idx    <= '0;
                        r_state  <= S_CHK;
                    end
                end
                S_CHK: begin
                    // read of entry i overlaps write-back of entry i-1, never the same entry
                    if (w_scan_end) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // alarms compare the means taken before any replacement
                    if (w_out_free) begin
                        r_o_mean_t   <= r_mean_t;
                        r_o_mean_h   <= r_mean_h;
                        r_o_mask_t   <= w_mask_t;
                        r_o_mask_h   <= w_mask_h;
                        r_o_cool_on  <= (r_mean_t > r_temp_high);
                        r_o_cool_off <= (r_mean_t < r_temp_low);
                        r_o_dehum_on <= (r_mean_h > r_hum_high);
                        r_o_hum_on   <= (r_mean_h < r_hum_low);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_mean_temp       = r_o_mean_t;
    assign o_mean_hum        = r_o_mean_h;
    assign o_temp_fault_mask = r_o_mask_t;
    assign o_hum_fault_mask  = r_o_mask_h;
    assign o_cooling_on      = r_o_cool_on;
    assign o_cooling_off     = r_o_cool_off;
    assign o_dehumidify_on   = r_o_dehum_on;
    assign o_humidify_on     = r_o_hum_on;

endmodule

// ===== hw/rtl/smf_ram.sv =====
// smf_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing
module smf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/smf_div.sv =====
// smf_div: signed by unsigned restoring divider, one quotient bit per cycle
// depends on smf_pkg
module smf_div import smf_pkg::*; #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [SUM_W-1:0]      i_dividend,
    input  logic [CNT_W-1:0]             i_divisor,
    output logic                         o_done,
    output logic signed [SMF_DATA_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic              r_neg;
    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;

    logic [CNT_W:0]    w_trial;
    logic              w_fit;
    logic [CNT_W:0]    w_diff;
    logic [SUM_W-1:0]  w_mag;
    logic [SUM_W-1:0]  w_res;

    // truncation toward zero: divide magnitudes, then restore the sign
    assign w_mag   = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_trial = {r_rem, r_q[SUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_res   = r_neg ? (~r_q + 1'b1) : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= w_mag;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_neg  <= i_dividend[SUM_W-1];
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[SUM_W-2:0], w_fit};
                r_rem <= w_fit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = w_res[SMF_DATA_W-1:0];

endmodule

// ===== hw/rtl/smf_lane.sv =====
// smf_lane: reading store of one sensor kind with sum and deviation check stages
// depends on smf_pkg and smf_ram
module smf_lane import smf_pkg::*; #(
    parameter int MAX_SENSORS = SMF_MAX_SENSORS,
    localparam int AW    = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1,
    localparam int CNT_W = $clog2(MAX_SENSORS + 1),
    localparam int SUM_W = SMF_DATA_W + $clog2(MAX_SENSORS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_lane_ctl                    i_ctl,
    input  logic [AW-1:0]                i_wr_idx,
    input  logic signed [SMF_DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]                i_rd_idx,
    input  logic [CNT_W-1:0]             i_count,
    input  logic signed [SMF_DATA_W-1:0] i_mean,
    input  logic [SMF_DEV_W-1:0]         i_dev_limit,
    output logic signed [SUM_W-1:0]      o_sum,
    output logic [SMF_MASK_W-1:0]        o_mask
);

    logic [MAX_SENSORS-1:0]         r_vld;
    logic                           r_p_vld;
    logic [AW-1:0]                  r_p_idx;
    logic                           r_p_ok;
    logic signed [SUM_W-1:0]        r_sum;
    logic [SMF_MASK_W-1:0]          r_mask;

    logic [SMF_DATA_W-1:0]          w_rdata;
    logic signed [SMF_DATA_W-1:0]   w_data;
    logic                           w_in_use;
    logic signed [SMF_DATA_W:0]     w_dev;
    logic [SMF_DATA_W:0]            w_abs;
    logic                           w_fix;
    logic                           w_we;
    logic [AW-1:0]                  w_waddr;
    logic [SMF_DATA_W-1:0]          w_wdata;

    // entries never written read as zero
    assign w_data   = r_p_ok ? $signed(w_rdata) : '0;
    assign w_in_use = (CNT_W'(r_p_idx) < i_count);
    assign w_dev    = (SMF_DATA_W+1)'(w_data) - (SMF_DATA_W+1)'(i_mean);
    assign w_abs    = w_dev[SMF_DATA_W] ? (SMF_DATA_W+1)'(-w_dev) : (SMF_DATA_W+1)'(w_dev);
    assign w_fix    = r_p_vld & i_ctl.chk & w_in_use &
                      (w_abs > (SMF_DATA_W+1)'(i_dev_limit));

    // external stores and mean write-back never coincide
    assign w_we    = i_ctl.wr | w_fix;
    assign w_waddr = i_ctl.wr ? i_wr_idx : r_p_idx;
    assign w_wdata = i_ctl.wr ? i_wr_data : i_mean;

    smf_ram #(
        .WIDTH (SMF_DATA_W),
        .DEPTH (MAX_SENSORS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_ctl.rd),
        .i_raddr (i_rd_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_p_vld <= 1'b0;
            r_sum   <= '0;
            r_mask  <= '0;
        end else begin
            r_p_vld <= i_ctl.rd;
            if (i_ctl.rd) begin
                r_p_idx <= i_rd_idx;
                r_p_ok  <= r_vld[i_rd_idx];
            end
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
            if (i_ctl.clr) begin
                r_sum  <= '0;
                r_mask <= '0;
            end else begin
                if (r_p_vld && !i_ctl.chk && w_in_use) begin
                    r_sum <= r_sum + SUM_W'(w_data);
                end
                // sensors above fifteen have no mask bit; the shift drops them
                if (w_fix) begin
                    r_mask <= r_mask | (SMF_MASK_W'(1) << r_p_idx);
                end
            end
        end
    end

    assign o_sum  = r_sum;
    assign o_mask = r_mask;

endmodule

// ===== bench/sensor_mean_fault_alarm_tb.sv =====
// sensor_mean_fault_alarm_tb: self-checking bench for the sensor mean and fault alarm block
// depends on smf_pkg and sensor_mean_fault_alarm; predicts every round and checks each result
`timescale 1ns / 100ps

module sensor_mean_fault_alarm_tb;
    import smf_pkg::*;

    // input transaction codes
    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;
    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_HUM  = 1'b1;

    // cycles to let the block settle once no round is pending
    localparam int SETTLE_CYCLES   = 100;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 75;

    // one expected round summary
    typedef struct {
        logic signed [SMF_DATA_W-1:0] mean_temp;
        logic signed [SMF_DATA_W-1:0] mean_hum;
        logic [SMF_MASK_W-1:0]        temp_mask;
        logic [SMF_MASK_W-1:0]        hum_mask;
        logic                         cool_on;
        logic                         cool_off;
        logic                         dehum_on;
        logic                         humid_on;
    } t_round;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic                         i_action;
    logic                         i_is_humidity;
    logic [3:0]                   i_sensor_index;
    logic signed [SMF_DATA_W-1:0] i_reading;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic signed [SMF_DATA_W-1:0] o_mean_temp;
    logic signed [SMF_DATA_W-1:0] o_mean_hum;
    logic [SMF_MASK_W-1:0]        o_temp_fault_mask;
    logic [SMF_MASK_W-1:0]        o_hum_fault_mask;
    logic                         o_cooling_on;
    logic                         o_cooling_off;
    logic                         o_dehumidify_on;
    logic                         o_humidify_on;
    logic                         i_cfg_we;
    logic [SMF_CFG_IDX_W-1:0]     i_cfg_idx;
    logic [SMF_DATA_W-1:0]        i_cfg_data;

    sensor_mean_fault_alarm #(
        .MAX_SENSORS(SMF_MAX_SENSORS)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_action          (i_action),
        .i_is_humidity     (i_is_humidity),
        .i_sensor_index    (i_sensor_index),
        .i_reading         (i_reading),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_mean_temp       (o_mean_temp),
        .o_mean_hum        (o_mean_hum),
        .o_temp_fault_mask (o_temp_fault_mask),
        .o_hum_fault_mask  (o_hum_fault_mask),
        .o_cooling_on      (o_cooling_on),
        .o_cooling_off     (o_cooling_off),
        .o_dehumidify_on   (o_dehumidify_on),
        .o_humidify_on     (o_humidify_on),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    // shadow copy of the registers, starting from their reset values
    logic [SMF_CNT_CFG_W-1:0]     sh_temp_count = SMF_TEMP_COUNT_RST;
    logic [SMF_CNT_CFG_W-1:0]     sh_hum_count  = SMF_HUM_COUNT_RST;
    logic signed [SMF_DATA_W-1:0] sh_temp_high  = SMF_TEMP_HIGH_RST;
    logic signed [SMF_DATA_W-1:0] sh_temp_low   = SMF_TEMP_LOW_RST;
    logic signed [SMF_DATA_W-1:0] sh_hum_high   = SMF_HUM_HIGH_RST;
    logic signed [SMF_DATA_W-1:0] sh_hum_low    = SMF_HUM_LOW_RST;
    logic [SMF_DEV_W-1:0]         sh_temp_dev   = SMF_TEMP_DEV_RST;
    logic [SMF_DEV_W-1:0]         sh_hum_dev    = SMF_HUM_DEV_RST;

    // shadow copy of both reading stores, all zero after reset
    logic signed [SMF_DATA_W-1:0] temp_copy [SMF_MAX_SENSORS];
    logic signed [SMF_DATA_W-1:0] hum_copy  [SMF_MAX_SENSORS];

    // rounds accepted but not yet seen on the output channel
    t_round pending_rounds [$];

    int  err_count  = 0;
    int  n_items    = 0;
    int  n_rounds   = 0;
    int  n_faults   = 0;
    bit  quiet      = 0;   // no idling on either side while set
    int  out_stall  = 0;

    // clock, 10 ns period
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // gap lengths: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SMF_DATA_W-1:0] clamp16(int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[SMF_DATA_W-1:0];
    endfunction

    // zero counts as one sensor, anything above the store depth as the full store
    function automatic int in_use(logic [SMF_CNT_CFG_W-1:0] c);
        if (c == 0) return 1;
        if (c > SMF_MAX_SENSORS) return SMF_MAX_SENSORS;
        return int'(c);
    endfunction

    // reading clustered around a base, with a share of fully random values
    function automatic logic signed [SMF_DATA_W-1:0] pick_reading(int base, int spread);
        int off;
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        off = $urandom_range(0, 2 * spread);
        return clamp16(base + off - spread);
    endfunction

    // a store lands only inside the sensors in use of its kind
    function automatic void apply_reading(logic kind, logic [3:0] idx,
                                          logic signed [SMF_DATA_W-1:0] value);
        if (kind == KIND_TEMP) begin
            if (int'(idx) < in_use(sh_temp_count)) temp_copy[idx] = value;
        end else begin
            if (int'(idx) < in_use(sh_hum_count)) hum_copy[idx] = value;
        end
    endfunction

    // means over the sensors in use, then flag and replace outliers
    function automatic t_round evaluate_round();
        int     nt;
        int     nh;
        int     sum_t;
        int     sum_h;
        int     mt;
        int     mh;
        int     d;
        t_round r;
        nt = in_use(sh_temp_count);
        nh = in_use(sh_hum_count);
        sum_t = 0;
        sum_h = 0;
        for (int i = 0; i < nt; i++) sum_t += int'(temp_copy[i]);
        for (int i = 0; i < nh; i++) sum_h += int'(hum_copy[i]);
        // integer division truncates toward zero
        mt = sum_t / nt;
        mh = sum_h / nh;
        r.temp_mask = '0;
        r.hum_mask  = '0;
        for (int i = 0; i < nt; i++) begin
            d = int'(temp_copy[i]) - mt;
            if (d < 0) d = -d;
            if (d > int'(sh_temp_dev)) begin
                if (i < SMF_MASK_W) r.temp_mask[i] = 1'b1;
                temp_copy[i] = mt[SMF_DATA_W-1:0];
            end
        end
        for (int i = 0; i < nh; i++) begin
            d = int'(hum_copy[i]) - mh;
            if (d < 0) d = -d;
            if (d > int'(sh_hum_dev)) begin
                if (i < SMF_MASK_W) r.hum_mask[i] = 1'b1;
                hum_copy[i] = mh[SMF_DATA_W-1:0];
            end
        end
        r.mean_temp = mt[SMF_DATA_W-1:0];
        r.mean_hum  = mh[SMF_DATA_W-1:0];
        // alarms use the means from before any replacement
        r.cool_on   = mt > int'(sh_temp_high);
        r.cool_off  = mt < int'(sh_temp_low);
        r.dehum_on  = mh > int'(sh_hum_high);
        r.humid_on  = mh < int'(sh_hum_low);
        n_faults += $countones(r.temp_mask) + $countones(r.hum_mask);
        return r;
    endfunction

    // one input transaction, optionally after a random gap with valid low
    task automatic send_item(input logic act, input logic kind, input logic [3:0] idx,
                             input logic signed [SMF_DATA_W-1:0] value);
        int     gap;
        t_round want;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_action       = act;
        i_is_humidity  = kind;
        i_sensor_index = idx;
        i_reading      = value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_items++;
        if (act == ACT_EVAL) begin
            want = evaluate_round();
            pending_rounds.insert(pending_rounds.size(), want);
        end else begin
            apply_reading(kind, idx, value);
        end
    endtask

    // drop valid so the last payload is not taken again
    task automatic in_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // hold the sender until every round has come out, then let the block settle
    task automatic wait_drain();
        in_idle();
        while (pending_rounds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // single register write, mirrored into the shadow copy
    task automatic cfg_write(input t_cfg_reg idx, input logic [SMF_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            CFG_TEMP_COUNT: sh_temp_count = data[SMF_CNT_CFG_W-1:0];
            CFG_HUM_COUNT:  sh_hum_count  = data[SMF_CNT_CFG_W-1:0];
            CFG_TEMP_HIGH:  sh_temp_high  = data;
            CFG_TEMP_LOW:   sh_temp_low   = data;
            CFG_HUM_HIGH:   sh_hum_high   = data;
            CFG_HUM_LOW:    sh_hum_low    = data;
            CFG_TEMP_DEV:   sh_temp_dev   = data[SMF_DEV_W-1:0];
            CFG_HUM_DEV:    sh_hum_dev    = data[SMF_DEV_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic program_all(input int tc, input int hc, input int th, input int tl,
                               input int hh, input int hl, input int td, input int hd);
        cfg_write(CFG_TEMP_COUNT, 16'(tc));
        cfg_write(CFG_HUM_COUNT,  16'(hc));
        cfg_write(CFG_TEMP_HIGH,  clamp16(th));
        cfg_write(CFG_TEMP_LOW,   clamp16(tl));
        cfg_write(CFG_HUM_HIGH,   clamp16(hh));
        cfg_write(CFG_HUM_LOW,    clamp16(hl));
        cfg_write(CFG_TEMP_DEV,   16'(td));
        cfg_write(CFG_HUM_DEV,    16'(hd));
    endtask

    // output side: random ready stalls, changed at the falling edge
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_stall > 0 && !quiet) begin
                i_out_ready = 1'b0;
                out_stall--;
            end else begin
                i_out_ready = 1'b1;
                out_stall   = 0;
                if ($urandom_range(0, 5) == 0) out_stall = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input logic signed [31:0] expv,
                               input logic signed [31:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            err_count++;
        end
    endtask

    // every result transaction against the oldest pending round
    always @(posedge i_clk) begin : check_results
        t_round want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rounds.size() == 0) begin
                $error("result transaction with no round pending");
                err_count++;
            end else begin
                want = pending_rounds.pop_front();
                n_rounds++;
                check_field("mean_temp", want.mean_temp, o_mean_temp);
                check_field("mean_hum", want.mean_hum, o_mean_hum);
                check_field("temp_fault_mask", {16'd0, want.temp_mask},
                            {16'd0, o_temp_fault_mask});
                check_field("hum_fault_mask", {16'd0, want.hum_mask},
                            {16'd0, o_hum_fault_mask});
                check_field("cooling_on", {31'd0, want.cool_on}, {31'd0, o_cooling_on});
                check_field("cooling_off", {31'd0, want.cool_off}, {31'd0, o_cooling_off});
                check_field("dehumidify_on", {31'd0, want.dehum_on},
                            {31'd0, o_dehumidify_on});
                check_field("humidify_on", {31'd0, want.humid_on}, {31'd0, o_humidify_on});
            end
        end
    end

    // reset settings: extremes of the reading, ignored writes, ignored evaluate fields
    task automatic test_reset_settings();
        send_item(ACT_STORE, KIND_TEMP, 4'd0, 16'sh7fff);
        send_item(ACT_STORE, KIND_TEMP, 4'd3, 16'sh8000);
        send_item(ACT_STORE, KIND_TEMP, 4'd1, 16'sh0100);
        send_item(ACT_STORE, KIND_HUM,  4'd0, 16'sh8000);
        send_item(ACT_STORE, KIND_HUM,  4'd3, 16'sh7fff);
        send_item(ACT_STORE, KIND_HUM,  4'd2, 16'sd12000);
        // index at or above the count of four is dropped
        send_item(ACT_STORE, KIND_TEMP, 4'd4, 16'sd1234);
        send_item(ACT_STORE, KIND_HUM,  4'd15, -16'sd1);
        // the other fields of an evaluate do not matter
        send_item(ACT_EVAL,  KIND_HUM,  4'd15, -16'sd1);
        // second round sees the replaced outliers
        send_item(ACT_EVAL,  KIND_TEMP, 4'd0, 16'sd0);
        wait_drain();
    endtask

    // count of zero acts as one, count beyond the store as the full store
    task automatic test_count_edges();
        cfg_write(CFG_TEMP_COUNT, 16'd0);
        cfg_write(CFG_HUM_COUNT, 16'd31);
        send_item(ACT_STORE, KIND_TEMP, 4'd0, 16'sh7fff);
        send_item(ACT_STORE, KIND_TEMP, 4'd1, 16'sd5);
        send_item(ACT_STORE, KIND_HUM,  4'd15, 16'sh8000);
        send_item(ACT_EVAL,  KIND_TEMP, 4'd7, 16'sh5a5a);
        wait_drain();
    endtask

    // band and deviation limits at both ends of their range
    task automatic test_limit_edges();
        program_all(16, 1, 32767, -32768, 32767, -32768, 0, 32767);
        send_item(ACT_STORE, KIND_TEMP, 4'd15, 16'sh7fff);
        send_item(ACT_EVAL,  KIND_HUM,  4'd3, 16'sd77);
        wait_drain();
        // inverted bands raise every alarm
        program_all(16, 16, -32768, 32767, -32768, 32767, 32767, 0);
        send_item(ACT_STORE, KIND_HUM,  4'd9, 16'sh8000);
        send_item(ACT_EVAL,  KIND_TEMP, 4'd0, 16'sd0);
        wait_drain();
    endtask

    // phases of random settings, mostly stores within the counts and regular rounds
    task automatic test_random_rounds();
        int         tc;
        int         hc;
        int         base_t;
        int         base_h;
        int         td;
        int         hd;
        int         th;
        int         tl;
        int         hh;
        int         hl;
        int         spread_t;
        int         spread_h;
        int         nt_use;
        int         nh_use;
        int         pick;
        logic       kind;
        logic [3:0] idx;
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drain();
            quiet  = (p == 5);
            base_t = $urandom_range(0, 40000);
            base_t = base_t - 20000;
            base_h = $urandom_range(0, 40000);
            base_h = base_h - 20000;
            tc = $urandom_range(1, 16);
            hc = $urandom_range(1, 16);
            td = $urandom_range(64, 4000);
            hd = $urandom_range(64, 4000);
            th = base_t + $urandom_range(0, 3000) - 1500;
            tl = base_t + $urandom_range(0, 3000) - 1500;
            hh = base_h + $urandom_range(0, 3000) - 1500;
            hl = base_h + $urandom_range(0, 3000) - 1500;
            case (p)
                0: begin tc = 16; hc = 16; end
                1: begin tc = 1;  hc = 1;  end
                2: begin tc = 0;  hc = 31; end
                3: begin td = 0;  hd = 0;  end
                4: begin
                    td = 32767; hd = 32767;
                    th = -32768; tl = 32767; hh = 32767; hl = -32768;
                end
                6: begin th = 32767; tl = -32768; hh = -32768; hl = 32767; end
                default: ;
            endcase
            program_all(tc, hc, th, tl, hh, hl, td, hd);
            nt_use   = in_use(5'(tc));
            nh_use   = in_use(5'(hc));
            spread_t = (td > 20000) ? 40000 : td + td / 2 + 16;
            spread_h = (hd > 20000) ? 40000 : hd + hd / 2 + 16;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // in even phases the sender holds off mid-phase until the output side catches up
                if (k == ITEMS_PER_PHASE / 2 && p % 2 == 0) wait_drain();
                pick = $urandom_range(0, 99);
                kind = 1'($urandom_range(0, 1));
                if (pick < 15) begin
                    send_item(ACT_EVAL, kind, 4'($urandom), 16'($urandom));
                end else if (pick < 20) begin
                    // noise: any index, often beyond the count
                    send_item(ACT_STORE, kind, 4'($urandom), 16'($urandom));
                end else begin
                    idx = 4'($urandom_range(0, (kind == KIND_HUM ? nh_use : nt_use) - 1));
                    send_item(ACT_STORE, kind, idx, (kind == KIND_HUM) ?
                              pick_reading(base_h, spread_h) :
                              pick_reading(base_t, spread_t));
                end
            end
        end
        quiet = 0;
    endtask

    initial begin
        for (int i = 0; i < SMF_MAX_SENSORS; i++) begin
            temp_copy[i] = '0;
            hum_copy[i]  = '0;
        end
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = ACT_STORE;
        i_is_humidity  = KIND_TEMP;
        i_sensor_index = '0;
        i_reading      = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_TEMP_COUNT;
        i_cfg_data     = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_settings();
        test_count_edges();
        test_limit_edges();
        test_random_rounds();

        // final drain, then the settle time
        wait_drain();
        $display("run covered %0d input transactions and %0d checked rounds", n_items,
                 n_rounds);
        $display("%0d sensor faults were flagged across %0d register phases", n_faults,
                 NUM_PHASES + 4);
        if (err_count == 0 && pending_rounds.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
